>>> rtl/ltt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltt_pkg: shared definitions of the lockless transposition table
// Table geometry, word layouts, operation codes and the command and status
// structs that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package ltt_pkg;

   // Table geometry. The slot index is the low bits of the hash.
   localparam int TT_INDEX_W = 16;
   localparam int TT_ENTRIES = 1 << TT_INDEX_W;

   // Field widths.
   localparam int TT_HASH_W  = 64;
   localparam int TT_DEPTH_W = 8;
   localparam int TT_SCORE_W = 16;
   localparam int TT_BOUND_W = 2;
   localparam int TT_MOVE_W  = 16;
   localparam int TT_WIN_W   = 18;
   localparam int TT_MODE_W  = 2;

   // Data word: depth, score, bound kind, move from the lowest bit up.
   localparam int TT_DATA_W = TT_DEPTH_W + TT_SCORE_W + TT_BOUND_W + TT_MOVE_W;
   localparam int TT_PAD_W  = TT_HASH_W - TT_DATA_W;

   // Stream word widths.
   localparam int TT_REQ_DATA_W = 144;
   localparam int TT_RSP_DATA_W = 64;

   // Operation codes carried in the request tuser.
   localparam logic [TT_MODE_W-1:0] MODE_PROBE = 2'd0;
   localparam logic [TT_MODE_W-1:0] MODE_STORE = 2'd1;
   localparam logic [TT_MODE_W-1:0] MODE_CLEAR = 2'd2;

   // Bound kinds.
   localparam logic [TT_BOUND_W-1:0] BOUND_EXACT = 2'd0;
   localparam logic [TT_BOUND_W-1:0] BOUND_UPPER = 2'd1;
   localparam logic [TT_BOUND_W-1:0] BOUND_LOWER = 2'd2;

   typedef struct packed {
      logic accept;     // request word taken this cycle
      logic store_wr;   // write the packed entry at the request slot
      logic sweep_wr;   // write zeros at the sweep address
      logic sweep_data; // the sweep also zeroes the data words
      logic load;       // load the response register
   } ltt_cmd_type;

   typedef struct packed {
      logic sweep_last; // sweep address is at the final entry
   } ltt_status_type;

endpackage

>>> rtl/ltt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltt_ctrl: sequencer of the lockless transposition table
// Runs the reset sweep, takes one request at a time, steps clear sweeps and
// owns the response valid flag.
// ----------------------------------------------------------------------------
module ltt_ctrl
   import ltt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic [TT_MODE_W-1:0] req_mode,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  ltt_status_type       status,
   output ltt_cmd_type          cmd
);

   localparam logic [1:0] ST_INIT  = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_EVAL  = 2'd2;
   localparam logic [1:0] ST_CLEAR = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.sweep_wr   = 1'b1;
            cmd.sweep_data = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               unique case (req_mode)
                  MODE_STORE: begin
                     cmd.store_wr = 1'b1;
                     state_in     = ST_EVAL;
                  end
                  MODE_CLEAR: begin
                     state_in = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_EVAL;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.sweep_wr = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            // The response register must be empty or emptying this cycle.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT;
         end
      endcase
   end

   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

>>> rtl/ltt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltt_datapath: table memories and probe evaluation
// Holds the check and data memories, the sweep counter, the captured request
// and the response register with the hit and cutoff logic in front of it.
// ----------------------------------------------------------------------------
module ltt_datapath
   import ltt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  ltt_cmd_type              cmd,
   input  logic [TT_REQ_DATA_W-1:0] req_tdata,
   input  logic [TT_MODE_W-1:0]     req_tuser,
   output logic [TT_RSP_DATA_W-1:0] rsp_tdata,
   output logic                     rsp_tuser,
   output ltt_status_type           status
);

   localparam int DEPTH_LO = TT_HASH_W;
   localparam int SCORE_LO = DEPTH_LO + TT_DEPTH_W;
   localparam int BOUND_LO = SCORE_LO + TT_SCORE_W;
   localparam int MOVE_LO  = BOUND_LO + TT_BOUND_W;
   localparam int ALPHA_LO = MOVE_LO + TT_MOVE_W;
   localparam int BETA_LO  = ALPHA_LO + TT_WIN_W;
   localparam int RSP_PAD  = TT_RSP_DATA_W - (TT_DATA_W + 1 + TT_WIN_W);

   logic [TT_HASH_W-1:0] check_mem [TT_ENTRIES];
   logic [TT_DATA_W-1:0] data_mem  [TT_ENTRIES];

   logic [TT_INDEX_W-1:0] sweep_addr_ff, sweep_addr_in;
   logic [TT_HASH_W-1:0]  rd_check_ff;
   logic [TT_DATA_W-1:0]  rd_data_ff;

   logic [TT_MODE_W-1:0]       mode_ff;
   logic [TT_HASH_W-1:0]       hash_ff;
   logic [TT_DEPTH_W-1:0]      depth_ff;
   logic signed [TT_WIN_W-1:0] alpha_ff;
   logic signed [TT_WIN_W-1:0] beta_ff;

   logic [TT_HASH_W-1:0]  req_hash;
   logic [TT_INDEX_W-1:0] req_index;
   logic [TT_DATA_W-1:0]  req_entry;

   logic [TT_INDEX_W-1:0] wr_addr;
   logic [TT_HASH_W-1:0]  check_wd;
   logic [TT_DATA_W-1:0]  data_wd;
   logic                  check_we, data_we;

   logic                         hit;
   logic [TT_DEPTH_W-1:0]        f_depth;
   logic [TT_SCORE_W-1:0]        f_score;
   logic [TT_BOUND_W-1:0]        f_bound;
   logic [TT_MOVE_W-1:0]         f_move;
   logic signed [TT_WIN_W-1:0]   score_ext;
   logic                         cut;
   logic signed [TT_WIN_W-1:0]   cut_score;

   logic                  hit_ff;
   logic [TT_DEPTH_W-1:0] depth_out_ff;
   logic [TT_SCORE_W-1:0] score_out_ff;
   logic [TT_BOUND_W-1:0] bound_out_ff;
   logic [TT_MOVE_W-1:0]  move_out_ff;
   logic                  cut_out_ff;
   logic [TT_WIN_W-1:0]   cscore_out_ff;

   assign req_hash  = req_tdata[TT_HASH_W-1:0];
   assign req_index = req_tdata[TT_INDEX_W-1:0];
   assign req_entry = {req_tdata[MOVE_LO +: TT_MOVE_W],
                       req_tdata[BOUND_LO +: TT_BOUND_W],
                       req_tdata[SCORE_LO +: TT_SCORE_W],
                       req_tdata[DEPTH_LO +: TT_DEPTH_W]};

   // Write port: a store writes both words, a sweep writes zeros.
   always_comb begin
      if (cmd.sweep_wr) begin
         wr_addr  = sweep_addr_ff;
         check_wd = '0;
         data_wd  = '0;
         check_we = 1'b1;
         data_we  = cmd.sweep_data;
      end else begin
         wr_addr  = req_index;
         check_wd = req_hash ^ {{TT_PAD_W{1'b0}}, req_entry};
         data_wd  = req_entry;
         check_we = cmd.store_wr;
         data_we  = cmd.store_wr;
      end
   end

   always_ff @(posedge clock) begin
      if (check_we) begin
         check_mem[wr_addr] <= check_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[wr_addr] <= data_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_check_ff <= check_mem[req_index];
         rd_data_ff  <= data_mem[req_index];
      end
   end

   // Sweep counter wraps back to zero after the final entry.
   assign sweep_addr_in     = cmd.sweep_wr ? sweep_addr_ff + TT_INDEX_W'(1) : sweep_addr_ff;
   assign status.sweep_last = &sweep_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
      end else begin
         sweep_addr_ff <= sweep_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         mode_ff  <= req_tuser;
         hash_ff  <= req_hash;
         depth_ff <= req_tdata[DEPTH_LO +: TT_DEPTH_W];
         alpha_ff <= req_tdata[ALPHA_LO +: TT_WIN_W];
         beta_ff  <= req_tdata[BETA_LO +: TT_WIN_W];
      end
   end

   // Probe evaluation on the registered read data.
   assign hit = (mode_ff == MODE_PROBE) &&
                ((rd_check_ff ^ {{TT_PAD_W{1'b0}}, rd_data_ff}) == hash_ff);
   assign f_depth   = rd_data_ff[0 +: TT_DEPTH_W];
   assign f_score   = rd_data_ff[TT_DEPTH_W +: TT_SCORE_W];
   assign f_bound   = rd_data_ff[TT_DEPTH_W + TT_SCORE_W +: TT_BOUND_W];
   assign f_move    = rd_data_ff[TT_DEPTH_W + TT_SCORE_W + TT_BOUND_W +: TT_MOVE_W];
   assign score_ext = {{(TT_WIN_W - TT_SCORE_W){f_score[TT_SCORE_W-1]}}, f_score};

   always_comb begin
      cut       = 1'b0;
      cut_score = '0;
      if (f_depth >= depth_ff) begin
         case (f_bound)
            BOUND_EXACT: begin
               cut       = 1'b1;
               cut_score = score_ext;
            end
            BOUND_UPPER: begin
               if (score_ext <= alpha_ff) begin
                  cut       = 1'b1;
                  cut_score = alpha_ff;
               end
            end
            BOUND_LOWER: begin
               if (score_ext >= beta_ff) begin
                  cut       = 1'b1;
                  cut_score = beta_ff;
               end
            end
            default: begin
               cut = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hit_ff        <= hit;
         depth_out_ff  <= hit ? f_depth : '0;
         score_out_ff  <= hit ? f_score : '0;
         bound_out_ff  <= hit ? f_bound : '0;
         move_out_ff   <= hit ? f_move : '0;
         cut_out_ff    <= hit && cut;
         cscore_out_ff <= (hit && cut) ? cut_score : '0;
      end
   end

   assign rsp_tdata = {{RSP_PAD{1'b0}}, cscore_out_ff, cut_out_ff, move_out_ff,
                       bound_out_ff, score_out_ff, depth_out_ff};
   assign rsp_tuser = hit_ff;

endmodule

>>> rtl/lockless_transposition_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lockless_transposition_table: direct-mapped search table with hash check
// Probe, store and clear operations on a table whose entries carry a data
// word and a check word equal to the hash XOR the data word.
// ----------------------------------------------------------------------------
// The table has 65536 entries, indexed by the low 16 bits of the hash. After
// reset the block zeroes both memories, one entry per cycle, and holds
// req_tready low until that sweep ends. Requests are handled one at a time:
// the memories are read at the edge that accepts a probe or a store, then the
// decision state makes the hit and cutoff decision and loads the response
// word once the output register is free, which sets rsp_tvalid; a new request
// word is taken only after the response of the last one has been loaded.
// A clear rewrites every check word through the single memory write port,
// so it walks all 65536 entries before its response is loaded. A response that
// is not taken holds the next request in the decision cycle until the output
// register frees up. Every request word, whatever its mode, gives exactly one
// response word; only a probe hit gives nonzero fields.
module lockless_transposition_table
   import ltt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // Request stream.
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tdata from bit 0 up: lookup_hash[63:0], depth_value[71:64],
   // entry_score[87:72], entry_bound[89:88], entry_move[105:90],
   // alpha_bound[123:106], beta_bound[141:124], zero fill[143:142].
   input  logic [TT_REQ_DATA_W-1:0] req_tdata,
   // tuser: mode[1:0].
   input  logic [TT_MODE_W-1:0]     req_tuser,
   // Response stream.
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tdata from bit 0 up: found_depth[7:0], found_score[23:8],
   // found_bound[25:24], found_move[41:26], cutoff[42],
   // cutoff_score[60:43], zero fill[63:61].
   output logic [TT_RSP_DATA_W-1:0] rsp_tdata,
   // tuser: hit.
   output logic                     rsp_tuser
);

   ltt_cmd_type    cmd;
   ltt_status_type status;

   // The controller sequences the sweeps and the single outstanding request.
   ltt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_mode   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath owns the memories, the captured request and the response.
   ltt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .status    (status)
   );

`ifndef SYNTHESIS
   // Only one request is in flight: acceptance drops ready for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while another is in flight");

   // A cutoff is only reported together with a hit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[42]) |-> rsp_tuser)
      else $error("cutoff reported without a hit");

   // A store write never coincides with a sweep write on the single port.
   assert property (@(posedge clock) disable iff (reset)
      !(cmd.store_wr && cmd.sweep_wr))
      else $error("store and sweep write in the same cycle");
`endif

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the lockless transposition table
// A queue-fed request driver and a response monitor run against a shadow copy
// of the table that predicts every response word. Directed words cover the
// corner cases, then randomized phases vary the idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import ltt_pkg::*;

   // The fourth mode code is not named in the package; the block ignores it.
   localparam logic [TT_MODE_W-1:0]  MODE_IGNORED = 2'd3;
   // A bound kind that is never produced by the search but may be stored.
   localparam logic [TT_BOUND_W-1:0] BOUND_UNUSED = 2'd3;

   // The reset sweep and every clear take a full pass over the 65536 entries.
   // A handful of clears plus ~1900 slowly paced words stays well below this.
   localparam int CYCLE_LIMIT  = 1_600_000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam int RECENT_MAX   = 48;
   localparam int PRINT_MAX    = 30;

   typedef struct {
      logic [TT_MODE_W-1:0]  mode;
      logic [TT_HASH_W-1:0]  hash;
      logic [TT_DEPTH_W-1:0] depth;
      logic [TT_SCORE_W-1:0] score;
      logic [TT_BOUND_W-1:0] bound;
      logic [TT_MOVE_W-1:0]  move;
      logic [TT_WIN_W-1:0]   alpha;
      logic [TT_WIN_W-1:0]   beta;
   } tt_request_type;

   typedef struct {
      logic                  hit;
      logic [TT_DEPTH_W-1:0] depth;
      logic [TT_SCORE_W-1:0] score;
      logic [TT_BOUND_W-1:0] bound;
      logic [TT_MOVE_W-1:0]  move;
      logic                  cutoff;
      logic [TT_WIN_W-1:0]   cut_score;
   } tt_response_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // tdata from bit 0 up: lookup_hash, depth_value, entry_score, entry_bound,
   // entry_move, alpha_bound, beta_bound, zero fill.
   logic [TT_REQ_DATA_W-1:0] req_tdata  = '0;
   // tuser: mode.
   logic [TT_MODE_W-1:0]     req_tuser  = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // tdata from bit 0 up: found_depth, found_score, found_bound, found_move,
   // cutoff, cutoff_score, zero fill.
   logic [TT_RSP_DATA_W-1:0] rsp_tdata;
   // tuser: hit.
   logic                     rsp_tuser;

   // Shadow copy of both memories. Reset leaves them all zero, as bit
   // vectors start out.
   bit [TT_HASH_W-1:0] shadow_check [TT_ENTRIES];
   bit [TT_DATA_W-1:0] shadow_data  [TT_ENTRIES];

   tt_request_type  request_queue[$];
   tt_response_type pending_responses[$];
   // Recent stores, kept so that random probes can aim at live entries.
   tt_request_type  recent_stores[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   logic hold_kick        = 1'b0;
   int hold_left          = 0;
   int cycle_count        = 0;
   int error_count        = 0;
   int response_count     = 0;
   int hit_count          = 0;
   int cutoff_count       = 0;
   int mode_count [4]     = '{default: 0};

   lockless_transposition_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Apply one accepted request word to the shadow table and work out the
   // response word the block has to give for it.
   function automatic tt_response_type table_access(input tt_request_type rq);
      tt_response_type        rs;
      logic [TT_INDEX_W-1:0]  slot;
      logic [TT_DATA_W-1:0]   word;
      int                     stored_score;
      int                     alpha_i;
      int                     beta_i;
      int                     cut_i;
      rs = '{default: '0};
      slot = rq.hash[TT_INDEX_W-1:0];
      case (rq.mode)
         MODE_STORE: begin
            word = {rq.move, rq.bound, rq.score, rq.depth};
            shadow_data[slot]  = word;
            shadow_check[slot] = rq.hash ^ {{TT_PAD_W{1'b0}}, word};
         end
         MODE_CLEAR: begin
            // Only the check words go; the data words survive a clear.
            foreach (shadow_check[i]) shadow_check[i] = '0;
         end
         MODE_PROBE: begin
            word = shadow_data[slot];
            if ((shadow_check[slot] ^ {{TT_PAD_W{1'b0}}, word}) == rq.hash) begin
               rs.hit   = 1'b1;
               rs.depth = word[7:0];
               rs.score = word[23:8];
               rs.bound = word[25:24];
               rs.move  = word[41:26];
               stored_score = int'($signed(word[23:8]));
               alpha_i      = int'($signed(rq.alpha));
               beta_i       = int'($signed(rq.beta));
               cut_i        = 0;
               // A cutoff is only trusted when the entry was searched at
               // least as deep as the caller asks for.
               if (rs.depth >= rq.depth) begin
                  if (rs.bound == BOUND_EXACT) begin
                     rs.cutoff = 1'b1;
                     cut_i     = stored_score;
                  end else if (rs.bound == BOUND_UPPER && stored_score <= alpha_i) begin
                     rs.cutoff = 1'b1;
                     cut_i     = alpha_i;
                  end else if (rs.bound == BOUND_LOWER && stored_score >= beta_i) begin
                     rs.cutoff = 1'b1;
                     cut_i     = beta_i;
                  end
               end
               rs.cut_score = cut_i[TT_WIN_W-1:0];
            end
         end
         default: ;
      endcase
      return rs;
   endfunction

   // Compare one field; a mismatch prints one line (up to a cap) and counts.
   task automatic report_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      if (got !== want) begin
         error_count++;
         if (error_count <= PRINT_MAX)
            $display("[%0t] mismatch on response %0d, %s: got %0h, expected %0h",
                     $time, response_count, what, got, want);
      end
   endtask

   // A window edge either anywhere in the legal range or within a few points
   // of a stored score, so that both sides of each bound test are reached.
   function automatic logic [TT_WIN_W-1:0] window_edge(input bit near, input int center);
      int v;
      if (near)
         v = center + int'($urandom_range(6)) - 3;
      else
         v = int'($urandom_range(199998)) - 99999;
      return v[TT_WIN_W-1:0];
   endfunction

   task automatic push_request(input logic [TT_MODE_W-1:0] mode,
                               input logic [TT_HASH_W-1:0] hash,
                               input logic [TT_DEPTH_W-1:0] depth,
                               input logic [TT_SCORE_W-1:0] score,
                               input logic [TT_BOUND_W-1:0] bound,
                               input logic [TT_MOVE_W-1:0] move,
                               input int alpha, input int beta);
      tt_request_type rq;
      rq.mode  = mode;
      rq.hash  = hash;
      rq.depth = depth;
      rq.score = score;
      rq.bound = bound;
      rq.move  = move;
      rq.alpha = alpha[TT_WIN_W-1:0];
      rq.beta  = beta[TT_WIN_W-1:0];
      request_queue.push_back(rq);
   endtask

   // Random traffic: mostly stores and probes aimed at recently stored
   // entries, with slot collisions, probes of cleared slots, stray hashes and
   // ignored words mixed in. A clear lands at clear_at unless that is negative.
   task automatic queue_random_requests(input int count, input int clear_at);
      tt_request_type rq;
      tt_request_type seen;
      int             roll;
      int             pick;
      bit             aimed;
      for (int n = 0; n < count; n++) begin
         rq.mode  = MODE_PROBE;
         rq.hash  = {$urandom, $urandom};
         rq.depth = TT_DEPTH_W'($urandom_range(255));
         rq.score = TT_SCORE_W'($urandom);
         rq.bound = TT_BOUND_W'($urandom_range(3));
         rq.move  = TT_MOVE_W'($urandom);
         rq.alpha = window_edge(1'b0, 0);
         rq.beta  = window_edge(1'b0, 0);
         roll = $urandom_range(99);
         if (n == clear_at) begin
            rq.mode = MODE_CLEAR;
         end else if (roll < 2) begin
            rq.mode = MODE_IGNORED;
         end else if (roll < 42) begin
            rq.mode = MODE_STORE;
            if ($urandom_range(9) != 0) rq.bound = TT_BOUND_W'($urandom_range(2));
            pick = $urandom_range(99);
            if (pick < 25 && recent_stores.size() != 0) begin
               rq.hash = recent_stores[$urandom_range(recent_stores.size() - 1)].hash;
            end else if (pick < 40) begin
               // Hash whose slot equals the low bits of its own data word:
               // after a clear, probing with the data word hits here.
               rq.hash[15:0] = {rq.score[7:0], rq.depth};
            end
            recent_stores.push_back(rq);
            if (recent_stores.size() > RECENT_MAX) void'(recent_stores.pop_front());
         end else if (recent_stores.size() != 0) begin
            seen  = recent_stores[$urandom_range(recent_stores.size() - 1)];
            pick  = $urandom_range(99);
            aimed = ($urandom_range(3) != 0);
            if (pick < 65) begin
               rq.hash = seen.hash;
               if (aimed) begin
                  rq.depth = TT_DEPTH_W'($urandom_range(seen.depth));
                  rq.alpha = window_edge(1'b1, int'($signed(seen.score)));
                  rq.beta  = window_edge(1'b1, int'($signed(seen.score)));
               end
            end else if (pick < 75) begin
               rq.hash[15:0] = seen.hash[15:0];
            end else if (pick < 83) begin
               rq.hash = {{TT_PAD_W{1'b0}}, seen.move, seen.bound, seen.score, seen.depth};
            end else if (pick < 86) begin
               rq.hash = '0;
            end
         end
         request_queue.push_back(rq);
      end
   endtask

   // Wait until every queued word has gone in and every response has come.
   task automatic drain_all();
      while (request_queue.size() != 0 || req_tvalid || pending_responses.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct,
                            input int count, input int clear_at);
      sender_idle_pct    <= sender_pct;
      receiver_stall_pct <= receiver_pct;
      queue_random_requests(count, clear_at);
      drain_all();
   endtask

   // Request driver. The word on the bus is predicted at the edge where it
   // is accepted; a new word is offered only when the bus is free, so tvalid
   // stays high across back-to-back words without a second assignment.
   always @(posedge clock) begin : drive_requests
      tt_request_type  offered;
      tt_response_type predicted;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted = table_access(offered);
            mode_count[offered.mode]++;
            if (predicted.hit) hit_count++;
            if (predicted.cutoff) cutoff_count++;
            pending_responses.push_back(predicted);
         end
         if (!req_tvalid || req_tready) begin
            if (request_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered = request_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, offered.beta, offered.alpha, offered.move,
                              offered.bound, offered.score, offered.depth, offered.hash};
               req_tuser  <= offered.mode;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here so that the sender keeps offering
   // words until the block backs up and drops req_tready.
   always @(posedge clock) begin
      if (reset)
         hold_left <= 0;
      else if (hold_kick)
         hold_left <= HOLD_CYCLES;
      else if (hold_left != 0)
         hold_left <= hold_left - 1;
   end

   // Response monitor: every accepted word is checked against the oldest
   // prediction, field by field.
   always @(posedge clock) begin : watch_responses
      tt_response_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_responses.size() == 0) begin
               report_field("unexpected response word", 64'd1, 64'd0);
            end else begin
               want = pending_responses.pop_front();
               report_field("hit",          64'(rsp_tuser),        64'(want.hit));
               report_field("found_depth",  64'(rsp_tdata[7:0]),   64'(want.depth));
               report_field("found_score",  64'(rsp_tdata[23:8]),  64'(want.score));
               report_field("found_bound",  64'(rsp_tdata[25:24]), 64'(want.bound));
               report_field("found_move",   64'(rsp_tdata[41:26]), 64'(want.move));
               report_field("cutoff",       64'(rsp_tdata[42]),    64'(want.cutoff));
               report_field("cutoff_score", 64'(rsp_tdata[60:43]), 64'(want.cut_score));
               report_field("zero fill",    64'(rsp_tdata[63:61]), 64'd0);
            end
            response_count++;
         end
         rsp_tready <= (hold_left == 0) && ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // Watchdog over the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, pending_responses.size());
         $display("FAIL");
         $finish;
      end
   end

   initial begin : sequencer
      logic [TT_HASH_W-1:0] self_hash;
      logic [TT_DATA_W-1:0] self_word;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words, no idling. The block is still sweeping its memories
      // after reset; the driver simply waits for req_tready.
      // A never-written slot has zero check and data, so hash 0 hits as an
      // exact entry of depth 0 and score 0; any other hash misses.
      push_request(MODE_PROBE, 64'd0, 8'd0, 16'h0000, BOUND_EXACT, 16'h0000, 0, 0);
      push_request(MODE_PROBE, 64'd0, 8'd1, 16'h0000, BOUND_EXACT, 16'h0000, 0, 0);
      push_request(MODE_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h0000, BOUND_EXACT,
                   16'h0000, -99999, 99999);
      // Largest fields, exact bound: the stored score comes back as cutoff.
      push_request(MODE_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 16'h7FFF, BOUND_EXACT,
                   16'hFFFF, 99999, -99999);
      push_request(MODE_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 16'h0000, BOUND_EXACT,
                   16'h0000, -99999, 99999);
      // Same slot, other upper bits: the check word rejects it.
      push_request(MODE_PROBE, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 16'h0000, BOUND_EXACT,
                   16'h0000, 0, 0);
      // Upper bound at the most negative score: cutoff exactly at alpha,
      // none just below it, none when the request is one level too deep.
      push_request(MODE_STORE, 64'h8000_0000_0000_1234, 8'd10, 16'h8000, BOUND_UPPER,
                   16'h0000, 0, 0);
      push_request(MODE_PROBE, 64'h8000_0000_0000_1234, 8'd10, 16'h0000, BOUND_EXACT,
                   16'h0000, -32768, 0);
      push_request(MODE_PROBE, 64'h8000_0000_0000_1234, 8'd10, 16'h0000, BOUND_EXACT,
                   16'h0000, -32769, 0);
      push_request(MODE_PROBE, 64'h8000_0000_0000_1234, 8'd11, 16'h0000, BOUND_EXACT,
                   16'h0000, 99999, 0);
      // Lower bound: cutoff at beta equal to the score, none just above it,
      // and the most negative window edge passed straight through.
      push_request(MODE_STORE, 64'h0123_4567_89AB_CDEF, 8'd20, 16'd500, BOUND_LOWER,
                   16'hA5A5, 0, 0);
      push_request(MODE_PROBE, 64'h0123_4567_89AB_CDEF, 8'd0, 16'h0000, BOUND_EXACT,
                   16'h0000, 0, 500);
      push_request(MODE_PROBE, 64'h0123_4567_89AB_CDEF, 8'd0, 16'h0000, BOUND_EXACT,
                   16'h0000, 0, 501);
      push_request(MODE_PROBE, 64'h0123_4567_89AB_CDEF, 8'd20, 16'h0000, BOUND_EXACT,
                   16'h0000, -99999, -99999);
      // The unused bound kind is kept as given and never cuts off.
      push_request(MODE_STORE, 64'h0F0F_F0F0_3C3C_C3C3, 8'd200, 16'h0000, BOUND_UNUSED,
                   16'h5A5A, 0, 0);
      push_request(MODE_PROBE, 64'h0F0F_F0F0_3C3C_C3C3, 8'd0, 16'h0000, BOUND_EXACT,
                   16'h0000, 99999, -99999);
      // An ignored word answers with zeros and changes nothing.
      push_request(MODE_IGNORED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 16'hFFFF, BOUND_UNUSED,
                   16'hFFFF, 99999, -99999);
      push_request(MODE_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h0000, BOUND_EXACT,
                   16'h0000, 0, 0);
      // A cleared slot keeps its data word, so after the clear the old hash
      // misses and a probe with the data word itself hits. The slot is chosen
      // to equal the low bits of that data word.
      self_word = {16'h0F0F, BOUND_LOWER, 16'h12AB, 8'h37};
      self_hash = 64'h5555_0000_0000_AB37;
      push_request(MODE_STORE, self_hash, 8'h37, 16'h12AB, BOUND_LOWER, 16'h0F0F, 0, 0);
      push_request(MODE_CLEAR, 64'd0, 8'd0, 16'h0000, BOUND_EXACT, 16'h0000, 0, 0);
      push_request(MODE_PROBE, self_hash, 8'd0, 16'h0000, BOUND_EXACT, 16'h0000, 0, 0);
      push_request(MODE_PROBE, {{TT_PAD_W{1'b0}}, self_word}, 8'd0, 16'h0000, BOUND_EXACT,
                   16'h0000, 0, 32'h12AB);
      push_request(MODE_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'h0000, BOUND_EXACT,
                   16'h0000, 0, 0);
      push_request(MODE_PROBE, 64'd0, 8'd0, 16'h0000, BOUND_EXACT, 16'h0000, 0, 0);
      drain_all();

      // Randomized phases with different idling on each side. Three of them
      // carry one clear each, which costs a full pass over the table.
      run_phase(0,  0,  450, $urandom_range(50, 400));
      run_phase(73, 0,  450, -1);
      run_phase(0,  73, 450, $urandom_range(50, 400));
      run_phase(34, 34, 450, $urandom_range(50, 400));

      // Back-pressure: the receiver holds off while the sender streams.
      sender_idle_pct    <= 0;
      receiver_stall_pct <= 0;
      queue_random_requests(100, -1);
      hold_kick <= 1'b1;
      @(negedge clock);
      hold_kick <= 1'b0;
      drain_all();

      // Let the pipeline settle so that a stray extra word gets noticed.
      repeat (DRAIN_CYCLES) @(negedge clock);
      report_field("missing response words", 64'd0, 64'(pending_responses.size()));

      $display("Covered %0d response words: %0d probes (%0d hits, %0d cutoffs), %0d stores,",
               response_count, mode_count[MODE_PROBE], hit_count, cutoff_count,
               mode_count[MODE_STORE]);
      $display("%0d clears and %0d ignored words, with %0d mismatches in %0d cycles.",
               mode_count[MODE_CLEAR], mode_count[MODE_IGNORED], error_count, cycle_count);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
rtl/ltt_pkg.sv
rtl/ltt_ctrl.sv
rtl/ltt_datapath.sv
rtl/lockless_transposition_table.sv
tb/sv/testbench.sv
